/* rtl/core/strided_local_memory_dma_assert.svh */
// Assertion macros shared by the checker.
`ifndef STRIDED_LOCAL_MEMORY_DMA_ASSERT_SVH
`define STRIDED_LOCAL_MEMORY_DMA_ASSERT_SVH

// same-cycle implication
`define SLMD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SLMD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/slmd_pkg.sv */
package slmd_pkg;

	localparam int BANK_BYTES_DEF = 4096;

	localparam int MAIN_AW  = 25;
	localparam int MADDR_W  = 24;
	localparam int LADDR_W  = 13;
	localparam int LEN_W    = 32;
	localparam int WORD_W   = 64;
	localparam int LOUT_W   = 12;

	localparam logic [MAIN_AW-1:0] MAIN_MEM_RESET = 25'd4194304;

	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_MOVE  = 2'd2;

endpackage

/* rtl/core/slmd_ram.sv */
module slmd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

/* rtl/core/strided_local_memory_dma.sv */
// A move transaction's result passes through stage 1 and then the result register.
// Throughput: one transaction per cycle unless req_stall, start and move alike;
// a write move reads local memory on accept and its registered data joins the result.
// Reset: asynchronous, active low; no transfer in progress, main memory size 4 MB.
// Local memory contents are not cleared by reset.
module strided_local_memory_dma #(
	parameter int BANK_BYTES = slmd_pkg::BANK_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [slmd_pkg::MAIN_AW-1:0]  cfg_data,

	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [1:0]                    cmd,
	input  logic [slmd_pkg::MADDR_W-1:0]  main_addr,
	input  logic [slmd_pkg::LADDR_W-1:0]  local_addr,
	input  logic [slmd_pkg::LEN_W-1:0]    length_word,
	input  logic [slmd_pkg::WORD_W-1:0]   main_word,

	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [slmd_pkg::MAIN_AW-1:0]  main_word_addr,
	output logic [slmd_pkg::LOUT_W-1:0]   local_word_addr,
	output logic                          bank_select,
	output logic [slmd_pkg::WORD_W-1:0]   out_word,
	output logic                          main_write_enable,
	output logic                          last,
	output logic [slmd_pkg::MAIN_AW-1:0]  final_main_addr,
	output logic [slmd_pkg::LOUT_W-1:0]   final_local_addr
);

	import slmd_pkg::*;

	localparam int BANK_AW     = $clog2(BANK_BYTES);
	localparam int WAW         = BANK_AW - 3;
	localparam int LOCAL_WORDS = 2 * BANK_BYTES / 8;

	// control state
	logic [MAIN_AW-1:0] mem_size_q;
	logic               busy_q;
	logic               dir_q;
	logic               bank_q;
	logic [MAIN_AW-1:0] mbase_q;
	logic [WAW-1:0]     lbase_q;
	logic [8:0]         word_idx_q;
	logic [9:0]         row_words_q;
	logic [8:0]         row_idx_q;
	logic [8:0]         row_total_q;
	logic [11:0]        skip_q;

	// stage 1: memory access in flight
	logic               valid_s1;
	logic               dir_s1;
	logic [MAIN_AW-1:0] maddr_s1;
	logic [LOUT_W-1:0]  laddr_s1;
	logic               bank_s1;
	logic               mwe_s1;
	logic               last_s1;
	logic [MAIN_AW-1:0] fmain_s1;
	logic [LOUT_W-1:0]  flocal_s1;

	// result register
	logic               rsp_valid_q;
	logic [MAIN_AW-1:0] maddr_q;
	logic [LOUT_W-1:0]  laddr_q;
	logic               bank_sel_q;
	logic [WORD_W-1:0]  word_q;
	logic               mwe_q;
	logic               last_q;
	logic [MAIN_AW-1:0] fmain_q;
	logic [LOUT_W-1:0]  flocal_q;

	logic               req_acc;
	logic               is_start;
	logic               move_go;
	logic               s1_go;
	logic [31:0]        la32;
	logic [MAIN_AW-1:0] maddr;
	logic [WAW-1:0]     lword;
	logic               in_range;
	logic               row_end;
	logic [8:0]         row_idx_nxt;
	logic               is_last;
	logic [MAIN_AW-1:0] mbase_nxt;
	logic [WAW-1:0]     lbase_nxt;
	logic               ram_we;
	logic               ram_re;
	logic [WAW:0]       ram_addr;
	logic [WORD_W-1:0]  ram_wdata;
	logic [WORD_W-1:0]  ram_rdata;

	assign cfg_ready = 1'b1;

	assign s1_go     = ~rsp_valid_q | ~rsp_stall;
	assign req_stall = valid_s1 & ~s1_go;
	assign req_acc   = req_valid & ~req_stall;
	assign is_start  = (cmd == CMD_READ) || (cmd == CMD_WRITE);
	assign move_go   = req_acc && (cmd == CMD_MOVE) && busy_q;

	assign la32 = 32'(local_addr);

	assign maddr       = mbase_q + MAIN_AW'({word_idx_q, 3'b000});
	assign lword       = lbase_q + WAW'(word_idx_q);
	assign in_range    = maddr < mem_size_q;
	assign row_end     = ({1'b0, word_idx_q} + 10'd1) >= row_words_q;
	assign row_idx_nxt = row_idx_q + 9'd1;
	assign is_last     = row_end && (row_idx_nxt >= row_total_q);
	assign mbase_nxt   = mbase_q + MAIN_AW'({row_words_q, 3'b000}) + MAIN_AW'(skip_q);
	assign lbase_nxt   = lbase_q + WAW'(row_words_q);

	assign ram_we    = move_go & ~dir_q;
	assign ram_re    = move_go & dir_q;
	assign ram_addr  = {bank_q, lword};
	assign ram_wdata = in_range ? main_word : '0;

	slmd_ram #(
		.WIDTH (WORD_W),
		.DEPTH (LOCAL_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_size_q  <= MAIN_MEM_RESET;
			busy_q      <= 1'b0;
			dir_q       <= 1'b0;
			bank_q      <= 1'b0;
			mbase_q     <= '0;
			lbase_q     <= '0;
			word_idx_q  <= '0;
			row_words_q <= '0;
			row_idx_q   <= '0;
			row_total_q <= '0;
			skip_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mem_size_q <= cfg_data;
			end
			if (req_acc && is_start) begin
				busy_q      <= 1'b1;
				dir_q       <= (cmd == CMD_WRITE);
				bank_q      <= la32[BANK_AW];
				mbase_q     <= MAIN_AW'({main_addr[MADDR_W-1:3], 3'b000});
				lbase_q     <= la32[BANK_AW-1:3];
				word_idx_q  <= '0;
				row_idx_q   <= '0;
				row_words_q <= {1'b0, length_word[11:3]} + 10'd1;
				row_total_q <= {1'b0, length_word[19:12]} + 9'd1;
				skip_q      <= {length_word[31:23], 3'b000};
			end else if (move_go) begin
				if (row_end) begin
					word_idx_q <= '0;
					mbase_q    <= mbase_nxt;
					lbase_q    <= lbase_nxt;
					row_idx_q  <= row_idx_nxt;
					if (is_last) begin
						busy_q <= 1'b0;
					end
				end else begin
					word_idx_q <= word_idx_q + 9'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (move_go) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_go) begin
			dir_s1    <= dir_q;
			maddr_s1  <= maddr;
			laddr_s1  <= LOUT_W'({lword, 3'b000});
			bank_s1   <= bank_q;
			mwe_s1    <= dir_q & in_range;
			last_s1   <= is_last;
			fmain_s1  <= is_last ? mbase_nxt : '0;
			flocal_s1 <= is_last ? LOUT_W'({lbase_nxt, 3'b000}) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_go) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && valid_s1) begin
			maddr_q    <= maddr_s1;
			laddr_q    <= laddr_s1;
			bank_sel_q <= bank_s1;
			word_q     <= dir_s1 ? ram_rdata : '0;
			mwe_q      <= mwe_s1;
			last_q     <= last_s1;
			fmain_q    <= fmain_s1;
			flocal_q   <= flocal_s1;
		end
	end

	assign rsp_valid         = rsp_valid_q;
	assign main_word_addr    = maddr_q;
	assign local_word_addr   = laddr_q;
	assign bank_select       = bank_sel_q;
	assign out_word          = word_q;
	assign main_write_enable = mwe_q;
	assign last              = last_q;
	assign final_main_addr   = fmain_q;
	assign final_local_addr  = flocal_q;

endmodule

/* rtl/core/slmd_checker.sv */
`include "strided_local_memory_dma_assert.svh"

module slmd_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [slmd_pkg::MAIN_AW-1:0]  cfg_data,
	input  logic                          rsp_valid,
	input  logic                          rsp_stall,
	input  logic [slmd_pkg::MAIN_AW-1:0]  main_word_addr,
	input  logic [slmd_pkg::LOUT_W-1:0]   local_word_addr,
	input  logic                          main_write_enable,
	input  logic                          last,
	input  logic [slmd_pkg::MAIN_AW-1:0]  final_main_addr,
	input  logic [slmd_pkg::LOUT_W-1:0]   final_local_addr
);

	import slmd_pkg::*;

	logic [MAIN_AW-1:0] size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= MAIN_MEM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			size_q <= cfg_data;
		end
	end

	`SLMD_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")
	`SLMD_ASSERT_IMP(a_we_range, clk, arst_n, rsp_valid && main_write_enable, main_word_addr < size_q, "main write enabled out of range")
	`SLMD_ASSERT_IMP(a_final_zero, clk, arst_n, rsp_valid && !last, final_main_addr == '0 && final_local_addr == '0, "final address set before last word")
	`SLMD_ASSERT_IMP(a_word_align, clk, arst_n, rsp_valid, main_word_addr[2:0] == 3'd0 && local_word_addr[2:0] == 3'd0 && final_local_addr[2:0] == 3'd0, "unaligned word address")

endmodule

bind strided_local_memory_dma slmd_checker u_slmd_checker (.*);
